@@ rtl/core/salc_pkg.sv @@
`timescale 1ns / 1ps

package salc_pkg;

	localparam int MAX_SETS  = 64;
	localparam int MAX_WAYS  = 8;
	localparam int ADDR_BITS = 48;

	localparam int SET_W  = $clog2(MAX_SETS);
	localparam int WAY_W  = $clog2(MAX_WAYS);
	localparam int RANK_W = 3;

	// access kinds
	localparam logic [1:0] MODE_MODIFY = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_SET_BITS    = 2'd0;
	localparam logic [1:0] CFG_BLOCK_BITS  = 2'd1;
	localparam logic [1:0] CFG_WAYS_IN_USE = 2'd2;

	typedef struct packed {
		logic [ADDR_BITS-1:0] address;
		logic [1:0]           mode;
	} salc_req_t;

	typedef struct packed {
		logic        was_hit;
		logic        was_eviction;
		logic        second_hit;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic [31:0] eviction_total;
	} salc_rsp_t;

	typedef struct packed {
		logic              valid;
		logic [RANK_W-1:0] rank;
	} salc_meta_t;

	typedef salc_meta_t [MAX_WAYS-1:0] salc_meta_row_t;

endpackage

@@ rtl/core/set_assoc_lru_cache_sim.sv @@
`timescale 1ns / 1ps

// Tag-only set-associative cache with LRU replacement. Each request carries a
// byte address and an access kind; the response tells hit, eviction and
// second hit (modify) and returns the running hit, miss and eviction counts.
// Tags sit in a memory with one read and one write port, read one way per
// cycle through a single tag comparator. A request holds the block through
// accept, address decode, set read, tag compare of each way in turn (ways
// being ways_in_use clamped to 1..8) and the recency/tag write-back, which
// waits while the previous response is still pending. Per-set valid bits and
// ranks live in a 64-row memory with one row-valid flop per set, so reset
// takes effect at once with no clearing pass. A new request is taken while the
// previous response still waits to be taken. The user must write configuration
// (set_bits, block_bits, ways_in_use) only when idle; it is not enforced.
module set_assoc_lru_cache_sim
	import salc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  salc_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output salc_rsp_t rsp,
	input  logic      cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_wdata
);

	typedef enum logic [2:0] {
		IDLE,
		DECODE,
		READ,
		SCAN,
		UPDATE
	} state_t;

	state_t state_q;

	logic [2:0] set_bits_q;
	logic [4:0] block_bits_q;
	logic [3:0] ways_in_use_q;

	logic [ADDR_BITS-1:0] addr_q;
	logic [1:0]           mode_q;
	logic [SET_W-1:0]     set_q;
	logic [ADDR_BITS-1:0] tag_q;

	logic [WAY_W-1:0] way_q;
	logic [WAY_W-1:0] cw_q;

	logic              hit_q;
	logic [WAY_W-1:0]  hit_way_q;
	logic              free_found_q;
	logic [WAY_W-1:0]  free_way_q;
	logic              vic_found_q;
	logic [WAY_W-1:0]  vic_way_q;
	logic [RANK_W-1:0] vic_rank_q;

	logic [31:0] hit_cnt_q;
	logic [31:0] miss_cnt_q;
	logic [31:0] evict_cnt_q;

	logic            rsp_valid_q;
	salc_rsp_t       rsp_q;
	logic [MAX_SETS-1:0] row_valid_q;

	logic [ADDR_BITS-1:0] tag_mem [MAX_SETS*MAX_WAYS];
	salc_meta_row_t       meta_mem [MAX_SETS];
	logic [ADDR_BITS-1:0] tag_rd_q;
	salc_meta_row_t       meta_rd_q;

	logic [3:0]           ways_eff;
	logic [WAY_W-1:0]     last_way;
	logic [ADDR_BITS-1:0] addr_shifted;
	logic [SET_W-1:0]     set_mask;
	logic [5:0]           tag_shamt;
	logic [SET_W-1:0]     set_d;
	logic [ADDR_BITS-1:0] tag_d;
	salc_meta_row_t       meta_cur;
	salc_meta_row_t       meta_new;
	salc_meta_t           cur_line;
	logic [RANK_W-1:0]    hit_rank;
	logic [WAY_W-1:0]     target;
	logic                 evict;
	logic                 second;
	logic                 proceed;
	logic                 tag_match;

	assign req_ready = (state_q == IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign proceed   = !rsp_valid_q || rsp_ready;

	always_comb begin
		if (ways_in_use_q == 4'd0) begin
			ways_eff = 4'd1;
		end else if (ways_in_use_q > 4'(MAX_WAYS)) begin
			ways_eff = 4'(MAX_WAYS);
		end else begin
			ways_eff = ways_in_use_q;
		end
		last_way = WAY_W'(ways_eff - 4'd1);
	end

	// set index wraps onto the available sets when set_bits exceeds them
	always_comb begin
		addr_shifted = addr_q >> block_bits_q;
		set_mask     = (SET_W'(1) << set_bits_q) - SET_W'(1);
		set_d        = addr_shifted[SET_W-1:0] & set_mask;
		tag_shamt    = 6'(set_bits_q) + 6'(block_bits_q);
		tag_d        = addr_q >> tag_shamt;
	end

	assign meta_cur  = row_valid_q[set_q] ? meta_rd_q : '0;
	assign cur_line  = meta_cur[cw_q];
	assign tag_match = (tag_rd_q == tag_q);
	assign hit_rank  = meta_cur[hit_way_q].rank;
	assign evict     = !hit_q && !free_found_q;
	assign target    = free_found_q ? free_way_q : vic_way_q;
	assign second    = (mode_q == MODE_MODIFY);

	always_comb begin
		meta_new = meta_cur;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (4'(w) < ways_eff && meta_cur[w].valid) begin
				if ((hit_q && meta_cur[w].rank < hit_rank)
				    || (!hit_q && WAY_W'(w) != target)) begin
					if (meta_cur[w].rank != RANK_W'(MAX_WAYS - 1)) begin
						meta_new[w].rank = meta_cur[w].rank + RANK_W'(1);
					end
				end
			end
			if (hit_q && WAY_W'(w) == hit_way_q) begin
				meta_new[w].rank = '0;
			end
			if (!hit_q && WAY_W'(w) == target) begin
				meta_new[w].valid = 1'b1;
				meta_new[w].rank  = '0;
			end
		end
	end

	// tag and recency memories, read data registered every cycle
	always_ff @(posedge clk) begin
		if (state_q == UPDATE && proceed) begin
			meta_mem[set_q] <= meta_new;
			if (!hit_q) begin
				tag_mem[{set_q, target}] <= tag_q;
			end
		end
		meta_rd_q <= meta_mem[set_q];
		tag_rd_q  <= tag_mem[{set_q, way_q}];
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			addr_q <= req.address;
			mode_q <= req.mode;
		end
		if (state_q == DECODE) begin
			set_q <= set_d;
			tag_q <= tag_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= IDLE;
			set_bits_q    <= 3'd0;
			block_bits_q  <= 5'd4;
			ways_in_use_q <= 4'd1;
			way_q         <= '0;
			cw_q          <= '0;
			hit_q         <= 1'b0;
			hit_way_q     <= '0;
			free_found_q  <= 1'b0;
			free_way_q    <= '0;
			vic_found_q   <= 1'b0;
			vic_way_q     <= '0;
			vic_rank_q    <= '0;
			hit_cnt_q     <= '0;
			miss_cnt_q    <= '0;
			evict_cnt_q   <= '0;
			row_valid_q   <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_q         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SET_BITS:    set_bits_q    <= cfg_wdata[2:0];
					CFG_BLOCK_BITS:  block_bits_q  <= cfg_wdata;
					CFG_WAYS_IN_USE: ways_in_use_q <= cfg_wdata[3:0];
					default: ;
				endcase
			end

			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				IDLE: begin
					if (req_valid) begin
						state_q <= DECODE;
					end
				end
				DECODE: begin
					way_q   <= '0;
					state_q <= READ;
				end
				READ: begin
					way_q        <= WAY_W'(1);
					cw_q         <= '0;
					hit_q        <= 1'b0;
					free_found_q <= 1'b0;
					vic_found_q  <= 1'b0;
					state_q      <= SCAN;
				end
				SCAN: begin
					if (cur_line.valid) begin
						if (!hit_q && tag_match) begin
							hit_q     <= 1'b1;
							hit_way_q <= cw_q;
						end
						if (!vic_found_q || cur_line.rank > vic_rank_q) begin
							vic_found_q <= 1'b1;
							vic_way_q   <= cw_q;
							vic_rank_q  <= cur_line.rank;
						end
					end else if (!free_found_q) begin
						free_found_q <= 1'b1;
						free_way_q   <= cw_q;
					end
					way_q <= way_q + WAY_W'(1);
					cw_q  <= cw_q + WAY_W'(1);
					if (cw_q == last_way) begin
						state_q <= UPDATE;
					end
				end
				UPDATE: begin
					// hold here while the previous response is still pending
					if (proceed) begin
						row_valid_q[set_q]   <= 1'b1;
						hit_cnt_q            <= hit_cnt_q + 32'(hit_q) + 32'(second);
						miss_cnt_q           <= miss_cnt_q + 32'(!hit_q);
						evict_cnt_q          <= evict_cnt_q + 32'(evict);
						rsp_q.was_hit        <= hit_q;
						rsp_q.was_eviction   <= evict;
						rsp_q.second_hit     <= second;
						rsp_q.hit_total      <= hit_cnt_q + 32'(hit_q) + 32'(second);
						rsp_q.miss_total     <= miss_cnt_q + 32'(!hit_q);
						rsp_q.eviction_total <= evict_cnt_q + 32'(evict);
						rsp_valid_q          <= 1'b1;
						state_q              <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule
